// ===== rtl/core/blc_pkg.sv =====
// Shared constants and controller/datapath interface types for the LED level controller.
package blc_pkg;

   // Settings image geometry.
   localparam int IMAGE_BYTES = 11;
   localparam int OFF_W       = $clog2(IMAGE_BYTES);
   localparam int ADDR_W      = OFF_W + 1;
   localparam int MEM_DEPTH   = 2 ** ADDR_W;

   // Command codes carried by an input item.
   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SET_TARGET  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GET_LEVEL   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GET_TARGET  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_BYTE   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BEGIN_WRITE = 3'd5;
   localparam logic [CMD_W-1:0] CMD_WRITE_BYTE  = 3'd6;

   // Reply status codes.
   localparam int STS_W = 2;
   localparam logic [STS_W-1:0] STS_OK     = 2'd0;
   localparam logic [STS_W-1:0] STS_REJECT = 2'd1;
   localparam logic [STS_W-1:0] STS_LAST   = 2'd2;

   // Reset value of the microseconds-per-tick register.
   localparam logic [15:0] US_PER_TICK_RESET = 16'd32;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_EXEC,
      OP_TAKE,
      OP_COPY_RD,
      OP_COPY_WR,
      OP_FLAGS_RD,
      OP_FLAGS_CHK,
      OP_DLY_RD,
      OP_DLY_CAP,
      OP_CMP,
      OP_LVL_RD,
      OP_LVL_CAP,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   // Status the datapath reports back to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             read_ok;
      logic             begin_ok;
      logic             flag_blink;
      logic             copy_last;
      logic             dly_last;
      logic             out_free;
   } dp_status_type;

endpackage

// ===== rtl/core/blc_ctrl.sv =====
// Sequencing state machine for the LED level controller.
module blc_ctrl import blc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_EXEC      = 13'b0000000000010,
      S_TAKE      = 13'b0000000000100,
      S_COPY_RD   = 13'b0000000001000,
      S_COPY_WR   = 13'b0000000010000,
      S_FLAGS_RD  = 13'b0000000100000,
      S_FLAGS_CHK = 13'b0000001000000,
      S_DLY_RD    = 13'b0000010000000,
      S_DLY_CAP   = 13'b0000100000000,
      S_CMP       = 13'b0001000000000,
      S_LVL_RD    = 13'b0010000000000,
      S_LVL_CAP   = 13'b0100000000000,
      S_OUT       = 13'b1000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // New items are taken only between items.
   assign req_stall = (state_ff != S_IDLE);

   // Next state and datapath operation.
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.op = OP_EXEC;
            case (status.cmd)
               CMD_GET_TARGET:  state_in = S_TAKE;
               CMD_READ_BYTE:   state_in = status.read_ok ? S_TAKE : S_FLAGS_RD;
               CMD_BEGIN_WRITE: state_in = status.begin_ok ? S_COPY_RD : S_FLAGS_RD;
               default:         state_in = S_FLAGS_RD;
            endcase
         end
         S_TAKE: begin
            cmd.op   = OP_TAKE;
            state_in = S_FLAGS_RD;
         end
         S_COPY_RD: begin
            cmd.op   = OP_COPY_RD;
            state_in = S_COPY_WR;
         end
         S_COPY_WR: begin
            cmd.op   = OP_COPY_WR;
            state_in = status.copy_last ? S_FLAGS_RD : S_COPY_RD;
         end
         S_FLAGS_RD: begin
            cmd.op   = OP_FLAGS_RD;
            state_in = S_FLAGS_CHK;
         end
         S_FLAGS_CHK: begin
            cmd.op   = OP_FLAGS_CHK;
            state_in = status.flag_blink ? S_DLY_RD : S_LVL_RD;
         end
         S_DLY_RD: begin
            cmd.op   = OP_DLY_RD;
            state_in = S_DLY_CAP;
         end
         S_DLY_CAP: begin
            cmd.op   = OP_DLY_CAP;
            state_in = status.dly_last ? S_CMP : S_DLY_RD;
         end
         S_CMP: begin
            cmd.op   = OP_CMP;
            state_in = S_LVL_RD;
         end
         S_LVL_RD: begin
            cmd.op   = OP_LVL_RD;
            state_in = S_LVL_CAP;
         end
         S_LVL_CAP: begin
            cmd.op   = OP_LVL_CAP;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.op = OP_OUT;
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/blc_datapath.sv =====
// Datapath of the LED level controller: image memory, timers, level and result register.
module blc_datapath import blc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   output dp_status_type    status,
   input  logic [CMD_W-1:0] req_command,
   input  logic [7:0]       req_value,
   input  logic [7:0]       req_byte_offset,
   input  logic [7:0]       req_byte_count,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic [STS_W-1:0] rsp_reply_status,
   output logic [7:0]       rsp_led_level,
   input  logic             csr_valid,
   input  logic [15:0]      csr_us_per_tick
);

   localparam logic [OFF_W-1:0] OFF_FLAGS   = OFF_W'(0);
   localparam logic [OFF_W-1:0] OFF_TARGET  = OFF_W'(1);
   localparam logic [OFF_W-1:0] OFF_LOW     = OFF_W'(2);
   localparam logic [OFF_W-1:0] OFF_DLY_ON  = OFF_W'(3);
   localparam logic [OFF_W-1:0] OFF_DLY_OFF = OFF_W'(7);
   localparam logic [OFF_W-1:0] LAST_OFF    = OFF_W'(IMAGE_BYTES - 1);
   localparam logic [1:0]       DLY_LAST    = 2'd3;

   // Item and working registers.
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [7:0]       val_ff, val_in;
   logic [7:0]       off_ff, off_in;
   logic [7:0]       cnt_ff, cnt_in;
   logic [7:0]       data_ff, data_in;
   logic [STS_W-1:0] sts_ff, sts_in;
   logic [OFF_W-1:0] idx_ff, idx_in;
   logic             blink_ff, blink_in;
   logic [31:0]      delay_ff, delay_in;
   logic [47:0]      prod_ff, prod_in;

   // Architectural state.
   logic [7:0]       level_ff, level_in;
   logic [31:0]      tick_ff, tick_in;
   logic [1:0]       phase_ff, phase_in;
   logic             active_ff, active_in;
   logic             receiving_ff, receiving_in;
   logic [7:0]       wpos_ff, wpos_in;
   logic [7:0]       left_ff, left_in;
   logic [15:0]      us_ff, us_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic [STS_W-1:0] rsp_sts_ff, rsp_sts_in;
   logic [7:0]       rsp_level_ff, rsp_level_in;

   // Image memory with a valid bit per entry so that unwritten bytes read as zero.
   logic [7:0]           mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] mem_valid_ff;
   logic [7:0]           rd_data_ff;
   logic                 rd_valid_ff;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [7:0]           wr_data;
   logic [7:0]           rd_byte;

   logic             act;
   logic             ina;
   logic             read_ok;
   logic             begin_ok;
   logic             out_free;
   logic [OFF_W-1:0] dly_base;

   assign act      = active_ff;
   assign ina      = ~active_ff;
   assign rd_byte  = rd_valid_ff ? rd_data_ff : 8'd0;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign read_ok  = (off_ff < 8'(IMAGE_BYTES));
   assign begin_ok = (off_ff <= 8'(IMAGE_BYTES)) &&
                     (({1'b0, off_ff} + {1'b0, cnt_ff}) <= 9'(IMAGE_BYTES));
   assign dly_base = phase_ff[act] ? OFF_DLY_ON : OFF_DLY_OFF;

   // Status toward the controller.
   assign status.cmd        = cmd_ff;
   assign status.read_ok    = read_ok;
   assign status.begin_ok   = begin_ok;
   assign status.flag_blink = rd_byte[0];
   assign status.copy_last  = (idx_ff == LAST_OFF);
   assign status.dly_last   = (idx_ff[1:0] == DLY_LAST);
   assign status.out_free   = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_reply_status = rsp_sts_ff;
   assign rsp_led_level    = rsp_level_ff;

   // Operation decode and next-state logic.
   always_comb begin
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      off_in       = off_ff;
      cnt_in       = cnt_ff;
      data_in      = data_ff;
      sts_in       = sts_ff;
      idx_in       = idx_ff;
      blink_in     = blink_ff;
      delay_in     = delay_ff;
      prod_in      = prod_ff;
      level_in     = level_ff;
      tick_in      = tick_ff;
      phase_in     = phase_ff;
      active_in    = active_ff;
      receiving_in = receiving_ff;
      wpos_in      = wpos_ff;
      left_in      = left_ff;
      us_in        = csr_valid ? csr_us_per_tick : us_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_sts_in   = rsp_sts_ff;
      rsp_level_in = rsp_level_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = val_ff;
      case (cmd.op)
         OP_LOAD: begin
            cmd_in  = req_command;
            val_in  = req_value;
            off_in  = req_byte_offset;
            cnt_in  = req_byte_count;
            data_in = 8'd0;
            sts_in  = STS_OK;
            idx_in  = '0;
         end
         OP_EXEC: begin
            case (cmd_ff)
               CMD_TICK: begin
                  if (tick_ff != '1) begin
                     tick_in = tick_ff + 32'd1;
                  end
               end
               CMD_SET_TARGET: begin
                  wr_en   = 1'b1;
                  wr_addr = {act, OFF_TARGET};
                  wr_data = val_ff;
               end
               CMD_GET_LEVEL: begin
                  data_in = level_ff;
               end
               CMD_GET_TARGET: begin
                  rd_en   = 1'b1;
                  rd_addr = {act, OFF_TARGET};
               end
               CMD_READ_BYTE: begin
                  if (read_ok) begin
                     rd_en   = 1'b1;
                     rd_addr = {act, off_ff[OFF_W-1:0]};
                  end else begin
                     sts_in = STS_REJECT;
                  end
               end
               CMD_BEGIN_WRITE: begin
                  if (begin_ok) begin
                     receiving_in  = 1'b1;
                     left_in       = cnt_ff;
                     wpos_in       = off_ff;
                     phase_in[ina] = 1'b0;
                     idx_in        = '0;
                  end else begin
                     receiving_in = 1'b0;
                     sts_in       = STS_REJECT;
                  end
               end
               CMD_WRITE_BYTE: begin
                  if (!receiving_ff) begin
                     sts_in = STS_REJECT;
                  end else if (left_ff == 8'd0) begin
                     sts_in = STS_LAST;
                  end else begin
                     if (wpos_ff < 8'(IMAGE_BYTES)) begin
                        wr_en   = 1'b1;
                        wr_addr = {ina, wpos_ff[OFF_W-1:0]};
                        wr_data = val_ff;
                     end
                     // The last staged byte swaps the images.
                     if (left_ff == 8'd1) begin
                        active_in    = ina;
                        tick_in      = '0;
                        receiving_in = 1'b0;
                        sts_in       = STS_LAST;
                     end
                     wpos_in = wpos_ff + 8'd1;
                     left_in = left_ff - 8'd1;
                  end
               end
               default: begin
               end
            endcase
         end
         OP_TAKE: begin
            data_in = rd_byte;
         end
         OP_COPY_RD: begin
            rd_en   = 1'b1;
            rd_addr = {act, idx_ff};
         end
         OP_COPY_WR: begin
            wr_en   = 1'b1;
            wr_addr = {ina, idx_ff};
            wr_data = rd_byte;
            idx_in  = idx_ff + OFF_W'(1);
         end
         OP_FLAGS_RD: begin
            rd_en   = 1'b1;
            rd_addr = {act, OFF_FLAGS};
            prod_in = {16'd0, tick_ff} * {32'd0, us_ff};
            idx_in  = '0;
         end
         OP_FLAGS_CHK: begin
            blink_in = rd_byte[0];
         end
         OP_DLY_RD: begin
            rd_en   = 1'b1;
            rd_addr = {act, dly_base + idx_ff};
         end
         OP_DLY_CAP: begin
            // Little-endian bytes shift in from the top.
            delay_in = {rd_byte, delay_ff[31:8]};
            idx_in   = idx_ff + OFF_W'(1);
         end
         OP_CMP: begin
            if (prod_ff >= {16'd0, delay_ff}) begin
               phase_in[act] = ~phase_ff[act];
               tick_in       = '0;
            end
         end
         OP_LVL_RD: begin
            rd_en   = 1'b1;
            rd_addr = {act, (blink_ff && !phase_ff[act]) ? OFF_LOW : OFF_TARGET};
         end
         OP_LVL_CAP: begin
            level_in = rd_byte;
         end
         OP_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff;
               rsp_sts_in   = sts_ff;
               rsp_level_in = level_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control and architectural state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= 8'd0;
         tick_ff      <= '0;
         phase_ff     <= '0;
         active_ff    <= 1'b0;
         receiving_ff <= 1'b0;
         wpos_ff      <= 8'd0;
         left_ff      <= 8'd0;
         us_ff        <= US_PER_TICK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         tick_ff      <= tick_in;
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         receiving_ff <= receiving_in;
         wpos_ff      <= wpos_in;
         left_ff      <= left_in;
         us_ff        <= us_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      val_ff       <= val_in;
      off_ff       <= off_in;
      cnt_ff       <= cnt_in;
      data_ff      <= data_in;
      sts_ff       <= sts_in;
      idx_ff       <= idx_in;
      blink_ff     <= blink_in;
      delay_ff     <= delay_in;
      prod_ff      <= prod_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_sts_ff   <= rsp_sts_in;
      rsp_level_ff <= rsp_level_in;
   end

   // Image memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= mem_valid_ff[rd_addr];
      end
   end

   // Entry valid bits; reset makes the whole image read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= '0;
      end else if (wr_en) begin
         mem_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // A saturated tick counter stays saturated on a further tick.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EXEC && cmd_ff == CMD_TICK && tick_ff == '1) |=> (tick_ff == '1))
      else $error("tick counter wrapped past its maximum");

   // A staged write never runs past the end of the image.
   assert property (@(posedge clock) disable iff (reset)
      receiving_ff |-> (({1'b0, wpos_ff} + {1'b0, left_ff}) <= 9'(IMAGE_BYTES)))
      else $error("staged write extends beyond the image");

   // A delivered result carries a defined status code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sts_ff <= STS_LAST))
      else $error("result carries an undefined status code");

endmodule

// ===== rtl/core/blink_led_level_controller.sv =====
// Top level of the LED level controller: controller and datapath.
//
//   Channel  Direction  Handshake                Payload
//   req_     in         req_valid / req_stall    command, value, byte_offset, byte_count
//   rsp_     out        rsp_valid / rsp_stall    read_data, reply_status, led_level
//   csr_     in         csr_valid / csr_ready    us_per_tick
//
// An item steps through load, execute, flags read and check, level read and capture
// and output; with blink on it also reads the four delay bytes and compares. A get
// target or an in-range read byte adds a take step, and a begin write that is taken
// copies the image byte by byte. The image memory gives one byte per cycle to the sequencer.
// Synchronous reset clears all control state; the image reads as zero at once.
// The result waits in an output register while the next item is taken; the block
// holds in its final step only if the previous result has not yet been taken.
module blink_led_level_controller import blc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [CMD_W-1:0] req_command,
   input  logic [7:0]       req_value,
   input  logic [7:0]       req_byte_offset,
   input  logic [7:0]       req_byte_count,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic [STS_W-1:0] rsp_reply_status,
   output logic [7:0]       rsp_led_level,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_us_per_tick
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // The register is always ready for a write.
   assign csr_ready = 1'b1;

   // Sequencer.
   blc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // Datapath.
   blc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .req_command      (req_command),
      .req_value        (req_value),
      .req_byte_offset  (req_byte_offset),
      .req_byte_count   (req_byte_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_reply_status (rsp_reply_status),
      .rsp_led_level    (rsp_led_level),
      .csr_valid        (csr_valid),
      .csr_us_per_tick  (csr_us_per_tick)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the LED level controller: directed and random command items.
module testbench import blc_pkg::*; ();

   // The one command code that the package leaves unnamed.
   localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 48;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 150;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [7:0]       value;
      logic [7:0]       byte_offset;
      logic [7:0]       byte_count;
   } led_cmd_type;

   typedef struct packed {
      logic [7:0]       read_data;
      logic [STS_W-1:0] reply_status;
      logic [7:0]       led_level;
   } led_reply_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [CMD_W-1:0] req_command = '0;
   logic [7:0]       req_value = '0;
   logic [7:0]       req_byte_offset = '0;
   logic [7:0]       req_byte_count = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [7:0]       rsp_read_data;
   logic [STS_W-1:0] rsp_reply_status;
   logic [7:0]       rsp_led_level;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [15:0]      csr_us_per_tick = '0;

   // Commands waiting to be driven and replies waiting to be seen.
   led_cmd_type   pending_cmds[$];
   led_reply_type expected_replies[$];

   // Predictor copy of the controller state.
   logic [7:0]  image_mem [2][IMAGE_BYTES];
   logic        blink_on_phase [2];
   logic        live_image;
   logic [31:0] tick_total;
   logic        staging;
   logic [7:0]  stage_pos;
   logic [7:0]  stage_left;
   logic [7:0]  level_now;
   logic [15:0] tick_us;

   int mismatches = 0;
   int items_queued = 0;
   int items_sent = 0;
   int replies_seen = 0;
   int swaps = 0;
   int toggles = 0;
   int rejects = 0;
   int scale_settings = 1;
   int idle_pct = 10;
   int req_gap = 0;
   int rsp_hold = 0;
   int quiet_cycles = 0;

   blink_led_level_controller DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_value        (req_value),
      .req_byte_offset  (req_byte_offset),
      .req_byte_count   (req_byte_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_reply_status (rsp_reply_status),
      .rsp_led_level    (rsp_led_level),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_us_per_tick  (csr_us_per_tick)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one command to the predictor and return the reply it should produce.
   function automatic led_reply_type predict_led_reply(input led_cmd_type c);
      led_reply_type r;
      logic          act;
      logic          ina;
      logic [63:0]   elapsed;
      logic [31:0]   delay_us;
      act = live_image;
      ina = ~live_image;
      r = '0;
      r.reply_status = STS_OK;
      case (c.command)
         CMD_TICK: begin
            if (tick_total != 32'hFFFF_FFFF) tick_total = tick_total + 1;
         end
         CMD_SET_TARGET: image_mem[act][1] = c.value;
         CMD_GET_LEVEL: r.read_data = level_now;
         CMD_GET_TARGET: r.read_data = image_mem[act][1];
         CMD_READ_BYTE: begin
            if (c.byte_offset < IMAGE_BYTES) r.read_data = image_mem[act][c.byte_offset];
            else r.reply_status = STS_REJECT;
         end
         CMD_BEGIN_WRITE: begin
            if (c.byte_offset <= IMAGE_BYTES && c.byte_count <= IMAGE_BYTES - c.byte_offset) begin
               staging = 1'b1;
               stage_left = c.byte_count;
               stage_pos = c.byte_offset;
               for (int i = 0; i < IMAGE_BYTES; i++) image_mem[ina][i] = image_mem[act][i];
               blink_on_phase[ina] = 1'b0;
            end else begin
               staging = 1'b0;
               r.reply_status = STS_REJECT;
            end
         end
         CMD_WRITE_BYTE: begin
            if (!staging) begin
               r.reply_status = STS_REJECT;
            end else if (stage_left == 0) begin
               r.reply_status = STS_LAST;
            end else begin
               if (stage_pos < IMAGE_BYTES) image_mem[ina][stage_pos] = c.value;
               // The last staged byte makes the staged image live.
               if (stage_left == 1) begin
                  live_image = ina;
                  tick_total = '0;
                  swaps++;
               end
               stage_pos = stage_pos + 1;
               stage_left = stage_left - 1;
               if (stage_left == 0) begin
                  staging = 1'b0;
                  r.reply_status = STS_LAST;
               end
            end
         end
         default: ;
      endcase

      // Level update from the live image, with the blink phase advanced on timeout.
      if (image_mem[live_image][0][0]) begin
         elapsed = 64'(tick_total) * 64'(tick_us);
         if (blink_on_phase[live_image])
            delay_us = {image_mem[live_image][6], image_mem[live_image][5],
                        image_mem[live_image][4], image_mem[live_image][3]};
         else
            delay_us = {image_mem[live_image][10], image_mem[live_image][9],
                        image_mem[live_image][8], image_mem[live_image][7]};
         if (elapsed >= 64'(delay_us)) begin
            blink_on_phase[live_image] = ~blink_on_phase[live_image];
            tick_total = '0;
            toggles++;
         end
         level_now = blink_on_phase[live_image] ? image_mem[live_image][1]
                                                : image_mem[live_image][2];
      end else begin
         level_now = image_mem[live_image][1];
      end
      r.led_level = level_now;
      if (r.reply_status == STS_REJECT) rejects++;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatches++;
      $display("MISMATCH reply %0d %s: got %0d, want %0d", replies_seen, field, got, want);
   endtask

   task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [7:0] val,
                           input logic [7:0] off, input logic [7:0] cnt);
      led_cmd_type c;
      c.command = cmd;
      c.value = val;
      c.byte_offset = off;
      c.byte_count = cnt;
      pending_cmds.push_back(c);
      items_queued++;
   endtask

   // Byte content for a staged write, biased so that blink delays stay reachable.
   function automatic logic [7:0] image_byte_for(input int pos);
      logic [7:0] b;
      b = 8'($urandom);
      case (pos)
         0: b[0] = ($urandom_range(0, 3) != 0);
         3, 7: if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(0, 31));
         4, 8: if ($urandom_range(0, 9) < 8) b = 8'h00;
         5, 6, 9, 10: if ($urandom_range(0, 9) != 0) b = 8'h00;
         default: ;
      endcase
      return b;
   endfunction

   // Mostly well-formed staged writes with random content, plus ticks, reads and noise.
   task automatic queue_random_phase(input int n);
      int start;
      int kind;
      int off;
      int cnt;
      start = items_queued;
      while (items_queued - start < n) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            if ($urandom_range(0, 3) == 0) begin
               off = 0;
               cnt = IMAGE_BYTES;
            end else begin
               off = $urandom_range(0, IMAGE_BYTES - 1);
               cnt = $urandom_range(1, IMAGE_BYTES - off);
            end
            push_cmd(CMD_BEGIN_WRITE, 8'($urandom), 8'(off), 8'(cnt));
            for (int k = 0; k < cnt; k++) begin
               // Now and then a sequence is abandoned or interleaved with other items.
               if ($urandom_range(0, 19) == 0) break;
               if ($urandom_range(0, 6) == 0)
                  push_cmd($urandom_range(0, 1) ? CMD_TICK : CMD_GET_LEVEL,
                           8'($urandom), 8'($urandom), 8'($urandom));
               push_cmd(CMD_WRITE_BYTE, image_byte_for(off + k), 8'($urandom), 8'($urandom));
            end
         end else if (kind < 70) begin
            repeat ($urandom_range(1, 24))
               push_cmd(($urandom_range(0, 4) == 0) ? CMD_GET_LEVEL : CMD_TICK,
                        8'($urandom), 8'($urandom), 8'($urandom));
         end else if (kind < 85) begin
            case ($urandom_range(0, 3))
               0: push_cmd(CMD_GET_LEVEL, 8'($urandom), 8'($urandom), 8'($urandom));
               1: push_cmd(CMD_GET_TARGET, 8'($urandom), 8'($urandom), 8'($urandom));
               2: push_cmd(CMD_READ_BYTE, 8'($urandom), 8'($urandom_range(0, IMAGE_BYTES - 1)),
                           8'($urandom));
               default: push_cmd(CMD_SET_TARGET, 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
         end else begin
            push_cmd(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   // Wait until every command is taken and answered, then let the block settle.
   task automatic drain_and_settle();
      while (pending_cmds.size() != 0 || expected_replies.size() != 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the tick scale register while the block is idle.
   task automatic write_tick_scale(input logic [15:0] us);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_us_per_tick <= us;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tick_us = us;
      scale_settings++;
   endtask

   // Command driver: presents queued items and predicts each one as it is taken.
   always @(posedge clock) begin
      led_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_replies.push_back(predict_led_reply(
               led_cmd_type'({req_command, req_value, req_byte_offset, req_byte_count})));
            items_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               nxt = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_command <= nxt.command;
               req_value <= nxt.value;
               req_byte_offset <= nxt.byte_offset;
               req_byte_count <= nxt.byte_count;
               if ($urandom_range(0, 99) < idle_pct) req_gap = $urandom_range(1, 18);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Reply monitor: checks each taken reply and stalls in random bursts.
   always @(posedge clock) begin
      led_reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
               report_mismatch("reply with none expected", 1, 0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", rsp_read_data, want.read_data);
               if (rsp_reply_status !== want.reply_status)
                  report_mismatch("reply_status", rsp_reply_status, want.reply_status);
               if (rsp_led_level !== want.led_level)
                  report_mismatch("led_level", rsp_led_level, want.led_level);
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            rsp_hold = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles in which no handshake completes.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("blink_led_level_controller regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus sequence: directed checks, then random phases over several tick scales.
   initial begin
      logic [7:0]  blink_image [IMAGE_BYTES];
      logic [15:0] us;
      for (int i = 0; i < IMAGE_BYTES; i++) begin
         image_mem[0][i] = 8'h00;
         image_mem[1][i] = 8'h00;
         blink_image[i] = 8'h00;
      end
      blink_on_phase[0] = 1'b0;
      blink_on_phase[1] = 1'b0;
      live_image = 1'b0;
      tick_total = '0;
      staging = 1'b0;
      stage_pos = '0;
      stage_left = '0;
      level_now = '0;
      tick_us = US_PER_TICK_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reads from the reset image, target extremes and out-of-range offsets.
      push_cmd(CMD_GET_LEVEL, 8'hFF, 8'hFF, 8'hFF);
      push_cmd(CMD_SET_TARGET, 8'hFF, 8'h00, 8'h00);
      push_cmd(CMD_GET_TARGET, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_GET_LEVEL, 8'h00, 8'h00, 8'h00);
      push_cmd(CMD_READ_BYTE, 8'h00, 8'(IMAGE_BYTES - 1), 8'h00);
      push_cmd(CMD_READ_BYTE, 8'h00, 8'(IMAGE_BYTES), 8'h00);
      push_cmd(CMD_READ_BYTE, 8'h00, 8'hFF, 8'hFF);
      push_cmd(CMD_RESERVED, 8'hFF, 8'hFF, 8'hFF);
      // Write byte with no staged write open, and begin writes that do not fit.
      push_cmd(CMD_WRITE_BYTE, 8'hAA, 8'h00, 8'h00);
      push_cmd(CMD_BEGIN_WRITE, 8'h00, 8'(IMAGE_BYTES + 1), 8'h00);
      push_cmd(CMD_BEGIN_WRITE, 8'h00, 8'd5, 8'd7);
      // An empty staged write: the next byte is answered as last but swaps nothing.
      push_cmd(CMD_BEGIN_WRITE, 8'h00, 8'(IMAGE_BYTES), 8'h00);
      push_cmd(CMD_WRITE_BYTE, 8'h55, 8'h00, 8'h00);
      // A full image with blink on and zero delays, so the phase flips on every item.
      blink_image[0] = 8'h01;
      blink_image[1] = 8'd200;
      blink_image[2] = 8'd17;
      push_cmd(CMD_BEGIN_WRITE, 8'h00, 8'h00, 8'(IMAGE_BYTES));
      for (int i = 0; i < IMAGE_BYTES; i++)
         push_cmd(CMD_WRITE_BYTE, blink_image[i], 8'h00, 8'h00);
      push_cmd(CMD_TICK, 8'h00, 8'h00, 8'h00);
      drain_and_settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: us = 16'd1;
            1: us = 16'hFFFF;
            2: us = US_PER_TICK_RESET;
            default: us = (p % 2) ? 16'($urandom_range(1, 64)) : 16'($urandom_range(1, 65535));
         endcase
         write_tick_scale(us);
         // No idling at all in the closing phase.
         if (p == RANDOM_PHASES - 1) idle_pct = 0;
         else if (p % 4 == 0) idle_pct = 12;
         else if (p % 4 == 1) idle_pct = 4;
         else if (p % 4 == 2) idle_pct = 0;
         else idle_pct = 25;
         queue_random_phase(PHASE_ITEMS);
         drain_and_settle();
      end

      $display("Drove %0d command items under %0d tick scale settings; %0d replies checked.",
               items_sent, scale_settings, replies_seen);
      $display("Predicted %0d image swaps, %0d blink phase changes, %0d rejected commands.",
               swaps, toggles, rejects);
      if (mismatches == 0)
         $display("blink_led_level_controller regression: pass");
      else
         $display("blink_led_level_controller regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/blc_pkg.sv
rtl/core/blc_ctrl.sv
rtl/core/blc_datapath.sv
rtl/core/blink_led_level_controller.sv
tb/testbench.sv
